/* rtl/core/bbbd_pkg.sv */
// bbbd_pkg: types, widths and codes shared by the band breach detector.
// No dependencies; compiled first.
package bbbd_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int PRICE_BITS  = 28;
  localparam int TIME_BITS   = 48;
  localparam int WIN_W       = 7;
  localparam int MULT_W      = 16;
  localparam int COOL_W      = 32;
  localparam int CONF_W      = 16;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int SUM_W       = PRICE_BITS + PTR_W;
  localparam int SQ_W        = 2 * PRICE_BITS + PTR_W;
  localparam int PROD_W      = 2 * PRICE_BITS;
  localparam int DW          = SQ_W + WIN_W + 1;
  localparam int RAD_W       = DW + 32;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int CNT_W       = 6;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MULT     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN = 2'd2;

  localparam logic [WIN_W-1:0]  WIN_RESET  = 7'd20;
  localparam logic [MULT_W-1:0] MULT_RESET = 16'd8192;

  typedef struct packed {
    logic [PRICE_BITS-1:0] close_price;
    logic [TIME_BITS-1:0]  timestamp_ms;
  } candle_t;

  typedef struct packed {
    logic                  is_sell;
    logic [CONF_W-1:0]     confidence;
    logic [PRICE_BITS-1:0] signal_price;
  } signal_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_SQ_SUB, ST_SQ_ADD, ST_MUL_WQ, ST_MUL_SS, ST_SQRT,
    ST_MUL_O, ST_CMP_A, ST_CMP_B, ST_PEN, ST_CONF, ST_DIV, ST_OUT
  } state_t;

endpackage

/* rtl/core/bbbd_if.sv */
// Request channels of the band breach detector: candles in, signals out.
// Depends on bbbd_pkg.
interface bbbd_in_if import bbbd_pkg::*; ();
  logic    valid;
  logic    ready;
  candle_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bbbd_out_if import bbbd_pkg::*; ();
  logic    valid;
  logic    ready;
  signal_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/bollinger_band_breach_detector.sv */
// Bollinger band breach detector top level.
// Usage:
//   in_candle takes one request per candle: close price and timestamp in ms.
//   out_signal gives zero or one request per candle: buy/sell flag, Q0.16
//   confidence and the close that caused it.
//   cfg_we/cfg_addr/cfg_wdata write window length (0), band multiplier (1)
//   and cooldown (2); writing the window length empties the window.
// Operation:
//   One candle at a time. A breaching candle on a full window has its result
//   in the output register after W*Q and S*S on the serial multiplier, the
//   square root, multiplier times deviation and the confidence divide, plus
//   control steps; the engine then returns to idle for the next candle.
//   Zero-width or saturated confidence skips the divide. No breach: idle
//   again after the band compare. Warm-up candles (window not full) return
//   to idle after the sum update. in_candle.ready only when idle.
// Reset: synchronous, active low; window empty, registers to 20 / 2.0 / 0.
// Stall: the result sits in an output register; a new candle may be taken
//   while it waits, and the engine holds its next result until it drains.
// Depends on bbbd_pkg and bbbd_if.
module bollinger_band_breach_detector import bbbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bbbd_in_if.sink               in_candle,
  bbbd_out_if.source            out_signal,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // configuration
  logic [WIN_W-1:0]  win_len_r;
  logic [MULT_W-1:0] mult_r;
  logic [COOL_W-1:0] cool_r;

  // window state
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [WIN_W-1:0]      fill_r, fill_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [TIME_BITS-1:0]  last_r, last_nxt;

  // per-candle working registers
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [WIN_W-1:0]      win_r, win_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [DW-1:0]         p_r, p_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [DW-1:0]         acc_r, acc_nxt;
  logic [DW-1:0]         mcand_r, mcand_nxt;
  logic [SUM_W-1:0]      mplr_r, mplr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [RAD_W-1:0]      rad_r, rad_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [DW-1:0]         o_r, o_nxt;
  logic [DW-1:0]         lo_r, lo_nxt;
  logic [DW-1:0]         hi_r, hi_nxt;
  logic                  ge_r, ge_nxt;
  logic                  cool_ok_r, cool_ok_nxt;
  logic                  sell_r, sell_nxt;
  logic                  hit_nxt;
  logic [DW-1:0]         pen_r, pen_nxt;
  logic [CONF_W-1:0]     q_r, q_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  signal_t out_data_r, out_data_nxt;

  // price ring
  logic [PRICE_BITS-1:0] ring [MAX_WINDOW];
  logic [PRICE_BITS-1:0] rd_data_r;
  logic [PTR_W-1:0]      rd_addr;
  logic                  ring_we;

  logic [WIN_W-1:0] w_eff;
  logic             in_acc;
  logic             win_clr;
  logic             full;
  logic [SUM_W-1:0] old_term;
  logic [DW-1:0]    sq_sum_new;
  logic [REM_W-1:0] sq_trial, sq_try;
  logic [DW-1:0]    m_term, width, div_r2;
  logic [TIME_BITS:0] tdiff;
  logic [WIN_W-1:0] ptr_inc;
  logic             out_free;
  logic [PRICE_BITS+WIN_W-1:0] pw;

  assign w_eff = (win_len_r < WIN_W'(2)) ? WIN_W'(2) :
                 (win_len_r > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_len_r;
  assign in_acc   = in_candle.valid && in_candle.ready;
  assign win_clr  = cfg_we && (cfg_addr == REG_WINDOW);
  assign rd_addr  = ({1'b0, wp_r} >= w_eff) ? '0 : wp_r;
  assign full     = (fill_r >= win_r);
  assign old_term = full ? SUM_W'(rd_data_r) : '0;
  assign ring_we  = (state_r == ST_READ);
  assign ptr_inc  = {1'b0, ptr_r} + WIN_W'(1);
  assign sq_sum_new = DW'(sq_r + SQ_W'(prod_r));
  assign m_term   = {{(DW-SUM_W-28){1'b0}}, sum_r, 28'd0};
  assign width    = {o_r[DW-2:0], 1'b0};
  assign div_r2   = {pen_r[DW-2:0], 1'b0};
  assign sq_trial = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign sq_try   = {1'b0, root_r, 2'b01};
  assign tdiff    = {1'b0, now_r} - {1'b0, last_r};
  assign out_free = !out_valid_r || out_signal.ready;
  // close times window, full width
  assign pw       = price_r * win_r;

  // handshake outputs
  assign in_candle.ready    = (state_r == ST_IDLE);
  assign out_signal.valid   = out_valid_r;
  assign out_signal.payload = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_SQ_SUB;
      ST_SQ_SUB: state_nxt = ST_SQ_ADD;
      ST_SQ_ADD: state_nxt = (fill_r < win_r) ? ST_IDLE : ST_MUL_WQ;
      ST_MUL_WQ: if (cnt_r == CNT_W'(1)) state_nxt = ST_MUL_SS;
      ST_MUL_SS: if (cnt_r == CNT_W'(1)) state_nxt = ST_SQRT;
      ST_SQRT:   if (cnt_r == CNT_W'(1)) state_nxt = ST_MUL_O;
      ST_MUL_O:  if (cnt_r == CNT_W'(1)) state_nxt = ST_CMP_A;
      ST_CMP_A:  state_nxt = ST_CMP_B;
      ST_CMP_B:  state_nxt = hit_nxt ? ST_PEN : ST_IDLE;
      ST_PEN:    state_nxt = ST_CONF;
      ST_CONF:   state_nxt = ((o_r == '0) || (pen_r >= width)) ? ST_OUT : ST_DIV;
      ST_DIV:    if (cnt_r == CNT_W'(1)) state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    wp_nxt = wp_r;   fill_nxt = fill_r; sum_nxt = sum_r; sq_nxt = sq_r;
    last_nxt = last_r;
    price_nxt = price_r; now_nxt = now_r; win_nxt = win_r; ptr_nxt = ptr_r;
    p_nxt = p_r; prod_nxt = prod_r;
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplr_nxt = mplr_r; cnt_nxt = cnt_r;
    rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r;
    o_nxt = o_r; lo_nxt = lo_r; hi_nxt = hi_r; ge_nxt = ge_r;
    cool_ok_nxt = cool_ok_r; sell_nxt = sell_r; hit_nxt = 1'b0;
    pen_nxt = pen_r; q_nxt = q_r;
    out_valid_nxt = out_valid_r && !out_signal.ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          price_nxt = in_candle.payload.close_price;
          now_nxt   = in_candle.payload.timestamp_ms;
          win_nxt   = w_eff;
          ptr_nxt   = rd_addr;
        end
      end
      ST_READ: begin
        prod_nxt = full ? rd_data_r * rd_data_r : '0;
        sum_nxt  = sum_r - old_term + SUM_W'(price_r);
        fill_nxt = full ? win_r : fill_r + WIN_W'(1);
        wp_nxt   = (ptr_inc >= win_r) ? '0 : ptr_inc[PTR_W-1:0];
        p_nxt    = {{(DW-PRICE_BITS-WIN_W-28){1'b0}}, pw, 28'd0};
      end
      ST_SQ_SUB: begin
        sq_nxt   = sq_r - SQ_W'(prod_r);
        prod_nxt = price_r * price_r;
      end
      ST_SQ_ADD: begin
        sq_nxt    = sq_sum_new[SQ_W-1:0];
        acc_nxt   = '0;
        mcand_nxt = DW'(sq_sum_new[SQ_W-1:0]);
        mplr_nxt  = SUM_W'(win_r);
        cnt_nxt   = CNT_W'(WIN_W);
      end
      ST_MUL_WQ: begin
        if (mplr_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt = {mcand_r[DW-2:0], 1'b0};
        mplr_nxt  = mplr_r >> 1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          mcand_nxt = DW'(sum_r);
          mplr_nxt  = sum_r;
          cnt_nxt   = CNT_W'(SUM_W);
        end
      end
      ST_MUL_SS: begin
        if (mplr_r[0]) acc_nxt = acc_r - mcand_r;
        mcand_nxt = {mcand_r[DW-2:0], 1'b0};
        mplr_nxt  = mplr_r >> 1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          rad_nxt  = {acc_nxt, 32'd0};
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = CNT_W'(ROOT_W);
        end
      end
      ST_SQRT: begin
        // two radicand bits per step, one root bit out
        if (sq_trial >= sq_try) begin
          rem_nxt  = sq_trial - sq_try;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          acc_nxt   = '0;
          mcand_nxt = DW'(root_nxt);
          mplr_nxt  = SUM_W'(mult_r);
          cnt_nxt   = CNT_W'(MULT_W);
        end
      end
      ST_MUL_O: begin
        if (mplr_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt = {mcand_r[DW-2:0], 1'b0};
        mplr_nxt  = mplr_r >> 1;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) o_nxt = acc_nxt;
      end
      ST_CMP_A: begin
        lo_nxt      = m_term - o_r;
        hi_nxt      = m_term + o_r;
        ge_nxt      = (m_term >= o_r);
        cool_ok_nxt = !tdiff[TIME_BITS] &&
                      (tdiff[TIME_BITS-1:0] >= TIME_BITS'(cool_r));
      end
      ST_CMP_B: begin
        // buy wins over sell
        sell_nxt = !(ge_r && (p_r <= lo_r));
        hit_nxt  = ((ge_r && (p_r <= lo_r)) || (p_r >= hi_r)) && cool_ok_r;
        if (hit_nxt) last_nxt = now_r;
      end
      ST_PEN: begin
        pen_nxt = sell_r ? (p_r - hi_r) : (lo_r - p_r);
      end
      ST_CONF: begin
        if (o_r == '0) q_nxt = '0;
        else if (pen_r >= width) q_nxt = '1;
        else begin
          q_nxt   = '0;
          cnt_nxt = CNT_W'(CONF_W);
        end
      end
      ST_DIV: begin
        if (div_r2 >= width) begin
          pen_nxt = div_r2 - width;
          q_nxt   = {q_r[CONF_W-2:0], 1'b1};
        end else begin
          pen_nxt = div_r2;
          q_nxt   = {q_r[CONF_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.is_sell      = sell_r;
          out_data_nxt.confidence   = q_r;
          out_data_nxt.signal_price = price_r;
        end
      end
      default: ;
    endcase
    if (win_clr) begin
      wp_nxt = '0; fill_nxt = '0; sum_nxt = '0; sq_nxt = '0;
    end
  end

  // ring: one write, one registered read
  always_ff @(posedge clk) begin
    if (ring_we) ring[ptr_r] <= price_r;
    rd_data_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_len_r   <= WIN_RESET;
      mult_r      <= MULT_RESET;
      cool_r      <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_WINDOW:   win_len_r <= cfg_wdata[WIN_W-1:0];
          REG_MULT:     mult_r    <= cfg_wdata[MULT_W-1:0];
          REG_COOLDOWN: cool_r    <= cfg_wdata[COOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    price_r    <= price_nxt;
    now_r      <= now_nxt;
    win_r      <= win_nxt;
    ptr_r      <= ptr_nxt;
    p_r        <= p_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplr_r     <= mplr_nxt;
    cnt_r      <= cnt_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    o_r        <= o_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    ge_r       <= ge_nxt;
    cool_ok_r  <= cool_ok_nxt;
    sell_r     <= sell_nxt;
    pen_r      <= pen_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
